// ===== rtl/tlg_pkg.sv =====
`timescale 1ns / 1ps

package tlg_pkg;

  localparam int FRAC_BITS = 16;

  localparam int IN_W  = 32;
  localparam int OUT_W = 32;

  // edge and potential differences
  localparam int D_W = IN_W + 1;
  // edge products and normal
  localparam int P_W = 2 * D_W;
  localparam int N_W = P_W + 1;

  // normal split into a signed high part and an unsigned low part
  localparam int NL_W = D_W + 1;
  localparam int NH_W = N_W - NL_W;
  localparam int PH_W = NH_W + D_W;
  localparam int PL_W = NL_W + 1 + D_W;

  // n x ab, n x bc
  localparam int C_W = N_W + D_W;

  // squared normal length
  localparam int DEN_W = 2 * N_W - 1;
  localparam int SQH_W = 2 * NH_W;
  localparam int SQM_W = NH_W + NL_W + 1;
  localparam int SQL_W = 2 * NL_W;

  // limbs of the cross products for the potential weighting
  localparam int LB_W = 32;
  localparam int LT_W = C_W - 2 * LB_W;
  localparam int LP_W = LB_W + 1 + D_W;
  localparam int TP_W = LT_W + D_W;

  localparam int NUM_W = C_W + D_W;
  localparam int MAG_W = NUM_W + FRAC_BITS;

  // quotient bits and divider remainder
  localparam int QB    = OUT_W;
  localparam int REM_W = DEN_W + QB;

  localparam logic [QB:0] LIM_NEG = (QB + 1)'(1) << (QB - 1);
  localparam logic [QB:0] LIM_POS = LIM_NEG - (QB + 1)'(1);

  typedef struct packed {
    logic neg;
    logic degen;
  } dctl_t;

endpackage

// ===== rtl/triangle_linear_gradient.sv =====
`timescale 1ns / 1ps

// Surface gradient of a linearly interpolated potential on one triangle.
// A triangle is taken in every clock cycle (busy is always low) and its
// result appears on out_valid after the start transfer has passed through:
// ten stages form the edges, the normal, its squared length and the
// weighted numerator with multiplies cut into 32-bit-sized partial products,
// then each component runs through its own pipelined restoring divider,
// one quotient bit per stage, plus entry, rounding and saturation stages.
// Results are presented for a single cycle and cannot be held off, so the
// receiver must take every out_valid transfer. A triangle with a zero normal
// returns a zero gradient with out_degenerate set.
module triangle_linear_gradient (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [tlg_pkg::IN_W-1:0]      in_ax,
  input  logic signed [tlg_pkg::IN_W-1:0]      in_ay,
  input  logic signed [tlg_pkg::IN_W-1:0]      in_az,
  input  logic signed [tlg_pkg::IN_W-1:0]      in_bx,
  input  logic signed [tlg_pkg::IN_W-1:0]      in_by,
  input  logic signed [tlg_pkg::IN_W-1:0]      in_bz,
  input  logic signed [tlg_pkg::IN_W-1:0]      in_cx,
  input  logic signed [tlg_pkg::IN_W-1:0]      in_cy,
  input  logic signed [tlg_pkg::IN_W-1:0]      in_cz,
  input  logic signed [tlg_pkg::IN_W-1:0]      in_pot_a,
  input  logic signed [tlg_pkg::IN_W-1:0]      in_pot_b,
  input  logic signed [tlg_pkg::IN_W-1:0]      in_pot_c,
  output logic                                 out_valid,
  output logic signed [tlg_pkg::OUT_W-1:0]     out_grad_x,
  output logic signed [tlg_pkg::OUT_W-1:0]     out_grad_y,
  output logic signed [tlg_pkg::OUT_W-1:0]     out_grad_z,
  output logic                                 out_degenerate
);

  logic signed [tlg_pkg::IN_W-1:0]   va [3];
  logic signed [tlg_pkg::IN_W-1:0]   vb [3];
  logic signed [tlg_pkg::IN_W-1:0]   vc [3];

  logic [10:1]                       vld_r;

  logic signed [tlg_pkg::D_W-1:0]    ab_r  [1:3][3];
  logic signed [tlg_pkg::D_W-1:0]    bc_r  [1:3][3];
  logic signed [tlg_pkg::D_W-1:0]    dpa_r [1:6];
  logic signed [tlg_pkg::D_W-1:0]    dpc_r [1:6];

  logic signed [tlg_pkg::P_W-1:0]    pa_r [3];
  logic signed [tlg_pkg::P_W-1:0]    pb_r [3];
  logic signed [tlg_pkg::N_W-1:0]    n_r  [3];

  logic signed [tlg_pkg::NH_W-1:0]   nh_w [3];
  logic signed [tlg_pkg::NL_W:0]     nl_w [3];

  logic signed [tlg_pkg::PH_W-1:0]   xah_r [3];
  logic signed [tlg_pkg::PL_W-1:0]   xal_r [3];
  logic signed [tlg_pkg::PH_W-1:0]   xbh_r [3];
  logic signed [tlg_pkg::PL_W-1:0]   xbl_r [3];
  logic signed [tlg_pkg::PH_W-1:0]   yah_r [3];
  logic signed [tlg_pkg::PL_W-1:0]   yal_r [3];
  logic signed [tlg_pkg::PH_W-1:0]   ybh_r [3];
  logic signed [tlg_pkg::PL_W-1:0]   ybl_r [3];
  logic signed [tlg_pkg::SQH_W-1:0]  sqh_r [3];
  logic signed [tlg_pkg::SQM_W-1:0]  sqm_r [3];
  logic [tlg_pkg::SQL_W-1:0]         sql_r [3];

  logic signed [tlg_pkg::C_W-1:0]    xa_r [3];
  logic signed [tlg_pkg::C_W-1:0]    xb_r [3];
  logic signed [tlg_pkg::C_W-1:0]    ya_r [3];
  logic signed [tlg_pkg::C_W-1:0]    yb_r [3];
  logic [tlg_pkg::DEN_W-1:0]         sq_r [3];

  logic signed [tlg_pkg::C_W-1:0]    nab_r [3];
  logic signed [tlg_pkg::C_W-1:0]    nbc_r [3];
  logic [tlg_pkg::DEN_W-1:0]         den_r [6:10];
  logic                              degen_r [7:10];

  logic signed [tlg_pkg::LP_W-1:0]   cp0_r [3];
  logic signed [tlg_pkg::LP_W-1:0]   cp1_r [3];
  logic signed [tlg_pkg::TP_W-1:0]   cp2_r [3];
  logic signed [tlg_pkg::LP_W-1:0]   ap0_r [3];
  logic signed [tlg_pkg::LP_W-1:0]   ap1_r [3];
  logic signed [tlg_pkg::TP_W-1:0]   ap2_r [3];

  logic signed [tlg_pkg::NUM_W-1:0]  cn_r  [3];
  logic signed [tlg_pkg::NUM_W-1:0]  an_r  [3];
  logic signed [tlg_pkg::NUM_W-1:0]  num_r [3];
  logic [tlg_pkg::NUM_W-1:0]         abs_w [3];

  logic                              neg_r [3];
  logic [tlg_pkg::MAG_W-1:0]         mag_r [3];
  tlg_pkg::dctl_t                    dctl_w [3];

  assign busy = 1'b0;

  assign va[0] = in_ax;
  assign va[1] = in_ay;
  assign va[2] = in_az;
  assign vb[0] = in_bx;
  assign vb[1] = in_by;
  assign vb[2] = in_bz;
  assign vc[0] = in_cx;
  assign vc[1] = in_cy;
  assign vc[2] = in_cz;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[9:1], start & ~busy};
    end
  end

  // stage 1: edges and potential differences
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      ab_r[1][k] <= tlg_pkg::D_W'(vb[k]) - tlg_pkg::D_W'(va[k]);
      bc_r[1][k] <= tlg_pkg::D_W'(vc[k]) - tlg_pkg::D_W'(vb[k]);
    end
    dpa_r[1] <= tlg_pkg::D_W'(in_pot_a) - tlg_pkg::D_W'(in_pot_b);
    dpc_r[1] <= tlg_pkg::D_W'(in_pot_c) - tlg_pkg::D_W'(in_pot_b);
  end

  // carries of the edges and potential differences
  always_ff @(posedge clk) begin
    ab_r[2] <= ab_r[1];
    ab_r[3] <= ab_r[2];
    bc_r[2] <= bc_r[1];
    bc_r[3] <= bc_r[2];
    for (int s = 2; s <= 6; s++) begin
      dpa_r[s] <= dpa_r[s-1];
      dpc_r[s] <= dpc_r[s-1];
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_comp
    localparam int I = (k + 1) % 3;
    localparam int J = (k + 2) % 3;

    assign nh_w[k]  = $signed(n_r[k][tlg_pkg::N_W-1:tlg_pkg::NL_W]);
    assign nl_w[k]  = $signed({1'b0, n_r[k][tlg_pkg::NL_W-1:0]});
    assign abs_w[k] = num_r[k][tlg_pkg::NUM_W-1] ? tlg_pkg::NUM_W'(-num_r[k])
                                                  : tlg_pkg::NUM_W'(num_r[k]);
    assign dctl_w[k] = '{neg: neg_r[k], degen: degen_r[10]};

    always_ff @(posedge clk) begin
      // stage 2: edge products for the normal
      pa_r[k] <= tlg_pkg::P_W'(ab_r[1][I]) * tlg_pkg::P_W'(bc_r[1][J]);
      pb_r[k] <= tlg_pkg::P_W'(ab_r[1][J]) * tlg_pkg::P_W'(bc_r[1][I]);

      // stage 3: normal
      n_r[k] <= tlg_pkg::N_W'(pa_r[k]) - tlg_pkg::N_W'(pb_r[k]);

      // stage 4: partial products on the split normal
      xah_r[k] <= tlg_pkg::PH_W'(nh_w[I]) * tlg_pkg::PH_W'(ab_r[3][J]);
      xal_r[k] <= tlg_pkg::PL_W'(nl_w[I]) * tlg_pkg::PL_W'(ab_r[3][J]);
      xbh_r[k] <= tlg_pkg::PH_W'(nh_w[J]) * tlg_pkg::PH_W'(ab_r[3][I]);
      xbl_r[k] <= tlg_pkg::PL_W'(nl_w[J]) * tlg_pkg::PL_W'(ab_r[3][I]);
      yah_r[k] <= tlg_pkg::PH_W'(nh_w[I]) * tlg_pkg::PH_W'(bc_r[3][J]);
      yal_r[k] <= tlg_pkg::PL_W'(nl_w[I]) * tlg_pkg::PL_W'(bc_r[3][J]);
      ybh_r[k] <= tlg_pkg::PH_W'(nh_w[J]) * tlg_pkg::PH_W'(bc_r[3][I]);
      ybl_r[k] <= tlg_pkg::PL_W'(nl_w[J]) * tlg_pkg::PL_W'(bc_r[3][I]);
      sqh_r[k] <= tlg_pkg::SQH_W'(nh_w[k]) * tlg_pkg::SQH_W'(nh_w[k]);
      sqm_r[k] <= tlg_pkg::SQM_W'(nh_w[k]) * tlg_pkg::SQM_W'(nl_w[k]);
      sql_r[k] <= tlg_pkg::SQL_W'(n_r[k][tlg_pkg::NL_W-1:0])
                * tlg_pkg::SQL_W'(n_r[k][tlg_pkg::NL_W-1:0]);

      // stage 5: recombine
      xa_r[k] <= (tlg_pkg::C_W'(xah_r[k]) <<< tlg_pkg::NL_W) + tlg_pkg::C_W'(xal_r[k]);
      xb_r[k] <= (tlg_pkg::C_W'(xbh_r[k]) <<< tlg_pkg::NL_W) + tlg_pkg::C_W'(xbl_r[k]);
      ya_r[k] <= (tlg_pkg::C_W'(yah_r[k]) <<< tlg_pkg::NL_W) + tlg_pkg::C_W'(yal_r[k]);
      yb_r[k] <= (tlg_pkg::C_W'(ybh_r[k]) <<< tlg_pkg::NL_W) + tlg_pkg::C_W'(ybl_r[k]);
      // cross term counts twice, hence the extra shift
      sq_r[k] <= (tlg_pkg::DEN_W'(sqh_r[k]) << (2 * tlg_pkg::NL_W))
               + (tlg_pkg::DEN_W'(sqm_r[k]) << (tlg_pkg::NL_W + 1))
               + tlg_pkg::DEN_W'(sql_r[k]);

      // stage 6: n x ab and n x bc
      nab_r[k] <= xa_r[k] - xb_r[k];
      nbc_r[k] <= ya_r[k] - yb_r[k];

      // stage 7: potential weighting in limbs
      cp0_r[k] <= tlg_pkg::LP_W'($signed({1'b0, nab_r[k][tlg_pkg::LB_W-1:0]}))
                * tlg_pkg::LP_W'(dpc_r[6]);
      cp1_r[k] <= tlg_pkg::LP_W'($signed({1'b0, nab_r[k][2*tlg_pkg::LB_W-1:tlg_pkg::LB_W]}))
                * tlg_pkg::LP_W'(dpc_r[6]);
      cp2_r[k] <= tlg_pkg::TP_W'($signed(nab_r[k][tlg_pkg::C_W-1:2*tlg_pkg::LB_W]))
                * tlg_pkg::TP_W'(dpc_r[6]);
      ap0_r[k] <= tlg_pkg::LP_W'($signed({1'b0, nbc_r[k][tlg_pkg::LB_W-1:0]}))
                * tlg_pkg::LP_W'(dpa_r[6]);
      ap1_r[k] <= tlg_pkg::LP_W'($signed({1'b0, nbc_r[k][2*tlg_pkg::LB_W-1:tlg_pkg::LB_W]}))
                * tlg_pkg::LP_W'(dpa_r[6]);
      ap2_r[k] <= tlg_pkg::TP_W'($signed(nbc_r[k][tlg_pkg::C_W-1:2*tlg_pkg::LB_W]))
                * tlg_pkg::TP_W'(dpa_r[6]);

      // stage 8: recombine limbs
      cn_r[k] <= (tlg_pkg::NUM_W'(cp2_r[k]) <<< (2 * tlg_pkg::LB_W))
               + (tlg_pkg::NUM_W'(cp1_r[k]) <<< tlg_pkg::LB_W)
               + tlg_pkg::NUM_W'(cp0_r[k]);
      an_r[k] <= (tlg_pkg::NUM_W'(ap2_r[k]) <<< (2 * tlg_pkg::LB_W))
               + (tlg_pkg::NUM_W'(ap1_r[k]) <<< tlg_pkg::LB_W)
               + tlg_pkg::NUM_W'(ap0_r[k]);

      // stage 9: numerator
      num_r[k] <= cn_r[k] + an_r[k];

      // stage 10: sign and scaled magnitude
      neg_r[k] <= num_r[k][tlg_pkg::NUM_W-1];
      mag_r[k] <= tlg_pkg::MAG_W'(abs_w[k]) << tlg_pkg::FRAC_BITS;
    end
  end

  always_ff @(posedge clk) begin
    den_r[6] <= sq_r[0] + sq_r[1] + sq_r[2];
    den_r[7] <= den_r[6];
    den_r[8] <= den_r[7];
    den_r[9] <= den_r[8];
    den_r[10] <= den_r[9];
    degen_r[7] <= (den_r[6] == '0);
    degen_r[8] <= degen_r[7];
    degen_r[9] <= degen_r[8];
    degen_r[10] <= degen_r[9];
  end

  tlg_div u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (vld_r[10]),
    .ctl      (dctl_w[0]),
    .mag      (mag_r[0]),
    .den      (den_r[10]),
    .valid    (out_valid),
    .grad     (out_grad_x),
    .degen    (out_degenerate)
  );

  tlg_div u_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (vld_r[10]),
    .ctl      (dctl_w[1]),
    .mag      (mag_r[1]),
    .den      (den_r[10]),
    .valid    (),
    .grad     (out_grad_y),
    .degen    ()
  );

  tlg_div u_div_z (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (vld_r[10]),
    .ctl      (dctl_w[2]),
    .mag      (mag_r[2]),
    .den      (den_r[10]),
    .valid    (),
    .grad     (out_grad_z),
    .degen    ()
  );

endmodule

// ===== rtl/tlg_div.sv =====
`timescale 1ns / 1ps

module tlg_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  tlg_pkg::dctl_t              ctl,
  input  logic [tlg_pkg::MAG_W-1:0]   mag,
  input  logic [tlg_pkg::DEN_W-1:0]   den,
  output logic                        valid,
  output logic [tlg_pkg::OUT_W-1:0]   grad,
  output logic                        degen
);

  logic [tlg_pkg::QB:0]        vld_r;
  tlg_pkg::dctl_t              ctl_r [0:tlg_pkg::QB];
  logic                        sat_r [0:tlg_pkg::QB];
  logic [tlg_pkg::REM_W-1:0]   rem_r [0:tlg_pkg::QB];
  logic [tlg_pkg::QB-1:0]      quo_r [0:tlg_pkg::QB];
  logic [tlg_pkg::DEN_W-1:0]   den_r [0:tlg_pkg::QB];

  logic                        rvld_r;
  tlg_pkg::dctl_t              rctl_r;
  logic                        rsat_r;
  logic [tlg_pkg::QB:0]        qr_r;

  logic                        rnd_nxt;
  logic [tlg_pkg::QB:0]        lim_nxt;
  logic [tlg_pkg::QB:0]        negq_nxt;
  logic [tlg_pkg::OUT_W-1:0]   grad_nxt;

  logic                        valid_r;
  logic [tlg_pkg::OUT_W-1:0]   grad_r;
  logic                        degen_r;

  // entry: anything at or above den * 2^QB saturates regardless of rounding
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    ctl_r[0] <= ctl;
    den_r[0] <= den;
    rem_r[0] <= tlg_pkg::REM_W'(mag);
    quo_r[0] <= '0;
    sat_r[0] <= tlg_pkg::REM_W'(mag) >= (tlg_pkg::REM_W'(den) << tlg_pkg::QB);
  end

  // one restoring step per stage, most significant quotient bit first
  for (genvar s = 0; s < tlg_pkg::QB; s++) begin : g_step
    logic [tlg_pkg::REM_W:0] sub_nxt;

    assign sub_nxt = {1'b0, rem_r[s]}
                   - ((tlg_pkg::REM_W + 1)'(den_r[s]) << (tlg_pkg::QB - 1 - s));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else begin
        vld_r[s+1] <= vld_r[s];
      end
    end

    always_ff @(posedge clk) begin
      ctl_r[s+1] <= ctl_r[s];
      den_r[s+1] <= den_r[s];
      sat_r[s+1] <= sat_r[s];
      if (!sub_nxt[tlg_pkg::REM_W]) begin
        rem_r[s+1] <= sub_nxt[tlg_pkg::REM_W-1:0];
        quo_r[s+1] <= quo_r[s] | (tlg_pkg::QB'(1) << (tlg_pkg::QB - 1 - s));
      end else begin
        rem_r[s+1] <= rem_r[s];
        quo_r[s+1] <= quo_r[s];
      end
    end
  end

  // round half away from zero on the magnitude
  assign rnd_nxt = {rem_r[tlg_pkg::QB][tlg_pkg::DEN_W-1:0], 1'b0}
                 >= {1'b0, den_r[tlg_pkg::QB]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rvld_r <= 1'b0;
    end else begin
      rvld_r <= vld_r[tlg_pkg::QB];
    end
  end

  always_ff @(posedge clk) begin
    rctl_r <= ctl_r[tlg_pkg::QB];
    rsat_r <= sat_r[tlg_pkg::QB];
    qr_r   <= (tlg_pkg::QB + 1)'(quo_r[tlg_pkg::QB]) + (tlg_pkg::QB + 1)'(rnd_nxt);
  end

  assign lim_nxt  = rctl_r.neg ? tlg_pkg::LIM_NEG : tlg_pkg::LIM_POS;
  assign negq_nxt = '0 - qr_r;

  always_comb begin
    if (rctl_r.degen) begin
      grad_nxt = '0;
    end else if (rsat_r || (qr_r > lim_nxt)) begin
      grad_nxt = lim_nxt[tlg_pkg::OUT_W-1:0];
    end else if (rctl_r.neg) begin
      grad_nxt = negq_nxt[tlg_pkg::OUT_W-1:0];
    end else begin
      grad_nxt = qr_r[tlg_pkg::OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= rvld_r;
    end
  end

  always_ff @(posedge clk) begin
    grad_r  <= grad_nxt;
    degen_r <= rctl_r.degen;
  end

  assign valid = valid_r;
  assign grad  = grad_r;
  assign degen = degen_r;

endmodule
